>>> hw/rtl/lp2c_pkg.sv
// Shared types, constants and the arctangent table of the polar to Cartesian converter.
`timescale 1ns / 1ps

package lp2c_pkg;

   localparam int QUALITY_SHIFT = 2;
   localparam int CORDIC_STAGES = 16;
   localparam int MAX_STAGES    = 24;
   localparam int STAGE_COUNT   = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

   localparam int ANGLE_WIDTH    = 16;
   localparam int RANGE_WIDTH    = 18;
   localparam int QUALITY_WIDTH  = 8;
   localparam int STRENGTH_WIDTH = 6;
   localparam int COORD_WIDTH    = 19;
   localparam int FRAC_BITS      = 12;

   // Rotator word: 30 bits of magnitude plus sign and growth headroom.
   localparam int ROT_WIDTH   = 34;
   localparam int GAIN_WIDTH  = 30;
   localparam int PROD_WIDTH  = RANGE_WIDTH + GAIN_WIDTH;
   localparam int PROD_SHIFT  = 30 - FRAC_BITS;
   localparam int ROUND_WIDTH = ROT_WIDTH - FRAC_BITS;

   localparam logic [GAIN_WIDTH-1:0] GAIN_Q30 = 30'd652032874;
   localparam logic signed [ROT_WIDTH-1:0] ROUND_HALF = ROT_WIDTH'(2048);
   localparam logic signed [ROUND_WIDTH:0] OUT_LIMIT = (ROUND_WIDTH + 1)'(262143);

   localparam int REQ_DATA_WIDTH = 48;
   localparam int RSP_DATA_WIDTH = 80;

   localparam logic [1:0] QUADRANT_0 = 2'd0;
   localparam logic [1:0] QUADRANT_1 = 2'd1;
   localparam logic [1:0] QUADRANT_2 = 2'd2;
   localparam logic [1:0] QUADRANT_3 = 2'd3;

   // Arctangent of 2^-i in phase units where 2^32 is a full circle.
   localparam logic [31:0] ATAN_PHASE [MAX_STAGES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      logic [ANGLE_WIDTH-1:0]    angle;
      logic [RANGE_WIDTH-1:0]    range;
      logic [STRENGTH_WIDTH-1:0] strength;
   } side_type;

   typedef struct packed {
      logic                        valid;
      logic signed [ROT_WIDTH-1:0] x;
      logic signed [ROT_WIDTH-1:0] y;
      logic signed [ROT_WIDTH-1:0] phase;
      side_type                    side;
   } rot_type;

endpackage

>>> hw/rtl/lp2c_front.sv
// Entry stage: prescales the range by the CORDIC gain, splits the angle and sizes the strength.
`timescale 1ns / 1ps

module lp2c_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [lp2c_pkg::ANGLE_WIDTH-1:0]       angle_code,
   input  logic [lp2c_pkg::RANGE_WIDTH-1:0]       range_quarter_mm,
   input  logic [lp2c_pkg::QUALITY_WIDTH-1:0]     quality,
   input  logic                                   out_ready,
   output lp2c_pkg::rot_type                      out_stage
);
   import lp2c_pkg::*;

   rot_type                    stage_ff;
   rot_type                    stage_in;
   logic [PROD_WIDTH-1:0]      product;
   logic [QUALITY_WIDTH-1:0]   shifted_quality;
   logic                       load;

   assign load     = !stage_ff.valid || out_ready;
   assign in_ready = load;

   always_comb begin
      product         = PROD_WIDTH'(range_quarter_mm) * PROD_WIDTH'(GAIN_Q30);
      shifted_quality = quality >> QUALITY_SHIFT;

      stage_in.valid = in_valid;
      stage_in.x     = ROT_WIDTH'(product[PROD_WIDTH-1:PROD_SHIFT]);
      stage_in.y     = '0;
      // The residual below one quadrant becomes a phase where 2^32 is a full circle.
      stage_in.phase = ROT_WIDTH'({angle_code[ANGLE_WIDTH-3:0], 16'h0000});
      stage_in.side.angle = angle_code;
      stage_in.side.range = range_quarter_mm;
      if (shifted_quality > QUALITY_WIDTH'((1 << STRENGTH_WIDTH) - 1)) begin
         stage_in.side.strength = '1;
      end else begin
         stage_in.side.strength = shifted_quality[STRENGTH_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (load) begin
         stage_ff <= stage_in;
      end
   end

   assign out_stage = stage_ff;

endmodule

>>> hw/rtl/lp2c_rotator.sv
// CORDIC rotation pipeline: one registered micro-rotation per stage.
`timescale 1ns / 1ps

module lp2c_rotator (
   input  logic                clock,
   input  logic                reset,
   input  lp2c_pkg::rot_type   in_stage,
   output logic                in_ready,
   input  logic                out_ready,
   output lp2c_pkg::rot_type   out_stage
);
   import lp2c_pkg::*;

   rot_type stage_ff  [STAGE_COUNT];
   rot_type stage_src [STAGE_COUNT];
   rot_type stage_in  [STAGE_COUNT];
   logic    load      [STAGE_COUNT + 1];

   assign load[STAGE_COUNT] = out_ready;
   assign stage_src[0]      = in_stage;

   for (genvar k = 0; k < STAGE_COUNT; k++) begin : g_stage
      if (k > 0) begin : g_link
         assign stage_src[k] = stage_ff[k-1];
      end

      // A stage takes new data when it is empty or its content moves on.
      assign load[k] = !stage_ff[k].valid || load[k+1];

      always_comb begin
         stage_in[k] = stage_src[k];
         if (!stage_src[k].phase[ROT_WIDTH-1]) begin
            stage_in[k].x     = stage_src[k].x - (stage_src[k].y >>> k);
            stage_in[k].y     = stage_src[k].y + (stage_src[k].x >>> k);
            stage_in[k].phase = stage_src[k].phase - ROT_WIDTH'(ATAN_PHASE[k]);
         end else begin
            stage_in[k].x     = stage_src[k].x + (stage_src[k].y >>> k);
            stage_in[k].y     = stage_src[k].y - (stage_src[k].x >>> k);
            stage_in[k].phase = stage_src[k].phase + ROT_WIDTH'(ATAN_PHASE[k]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[k].valid <= 1'b0;
         end else if (load[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign in_ready  = load[0];
   assign out_stage = stage_ff[STAGE_COUNT-1];

endmodule

>>> hw/rtl/lp2c_back.sv
// Output stage: rounds, applies the quadrant rotation, saturates and holds the response.
`timescale 1ns / 1ps

module lp2c_back (
   input  logic                                     clock,
   input  logic                                     reset,
   input  lp2c_pkg::rot_type                        in_stage,
   output logic                                     in_ready,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output logic signed [lp2c_pkg::COORD_WIDTH-1:0]  x_out,
   output logic signed [lp2c_pkg::COORD_WIDTH-1:0]  y_out,
   output lp2c_pkg::side_type                       side_out
);
   import lp2c_pkg::*;

   logic signed [ROT_WIDTH-1:0]     x_sum;
   logic signed [ROT_WIDTH-1:0]     y_sum;
   logic signed [ROUND_WIDTH:0]     x_round;
   logic signed [ROUND_WIDTH:0]     y_round;
   logic signed [ROUND_WIDTH:0]     x_rot;
   logic signed [ROUND_WIDTH:0]     y_rot;
   logic signed [COORD_WIDTH-1:0]   x_in;
   logic signed [COORD_WIDTH-1:0]   y_in;
   logic                            valid_ff;
   logic signed [COORD_WIDTH-1:0]   x_ff;
   logic signed [COORD_WIDTH-1:0]   y_ff;
   side_type                        side_ff;
   logic                            load;

   assign load     = !valid_ff || out_ready;
   assign in_ready = load;

   function automatic logic signed [COORD_WIDTH-1:0] clamp_out(
      input logic signed [ROUND_WIDTH:0] v
   );
      logic signed [ROUND_WIDTH:0] c;
      begin
         if (v > OUT_LIMIT) begin
            c = OUT_LIMIT;
         end else if (v < -OUT_LIMIT) begin
            c = -OUT_LIMIT;
         end else begin
            c = v;
         end
         clamp_out = c[COORD_WIDTH-1:0];
      end
   endfunction

   always_comb begin
      x_sum   = in_stage.x + ROUND_HALF;
      y_sum   = in_stage.y + ROUND_HALF;
      x_round = (ROUND_WIDTH + 1)'($signed(x_sum[ROT_WIDTH-1:FRAC_BITS]));
      y_round = (ROUND_WIDTH + 1)'($signed(y_sum[ROT_WIDTH-1:FRAC_BITS]));
      case (in_stage.side.angle[ANGLE_WIDTH-1 -: 2])
         QUADRANT_1: begin
            x_rot = -y_round;
            y_rot = x_round;
         end
         QUADRANT_2: begin
            x_rot = -x_round;
            y_rot = -y_round;
         end
         QUADRANT_3: begin
            x_rot = y_round;
            y_rot = -x_round;
         end
         default: begin
            x_rot = x_round;
            y_rot = y_round;
         end
      endcase
      x_in = clamp_out(x_rot);
      y_in = clamp_out(y_rot);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         side_ff <= in_stage.side;
      end
   end

   assign out_valid = valid_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign side_out  = side_ff;

endmodule

>>> hw/rtl/lidar_polar_to_cartesian.sv
// Top level of the range-scanner polar to Cartesian converter.
`timescale 1ns / 1ps

// Each request carries one scanner sample and yields one response with
// x = r*cos(angle) and y = r*sin(angle) in signed quarter millimetres,
// saturated to +-262143, plus the range and angle passed through, the
// strength (quality shifted right, capped at 63) and, on rsp_tuser, a flag
// that is set when the range is nonzero. A new request is taken every cycle
// while the response side takes results. The data passes in order through the
// gain multiplier register, the register of each CORDIC micro-rotation and the
// output register, which also rounds, rotates by quadrant and saturates. Every
// stage has its own valid bit and loads when it is empty or its content moves
// on, so backpressure on the response side stalls only the occupied stages.
module lidar_polar_to_cartesian (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // Fields from bit 0: angle_code[15:0], range_quarter_mm[33:16], quality[41:34], zero pad.
   input  logic [lp2c_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // Fields from bit 0: x_quarter_mm[18:0], y_quarter_mm[37:19], range_out[55:38],
   // angle_out[71:56], strength[77:72], zero pad.
   output logic [lp2c_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   // Fields from bit 0: point_valid[0].
   output logic                                  rsp_tuser
);
   import lp2c_pkg::*;

   rot_type                        front_stage;
   rot_type                        rot_stage;
   logic                           rot_ready;
   logic                           back_ready;
   logic signed [COORD_WIDTH-1:0]  x_out;
   logic signed [COORD_WIDTH-1:0]  y_out;
   side_type                       side_out;

   lp2c_front u_front (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_tvalid),
      .in_ready         (req_tready),
      .angle_code       (req_tdata[15:0]),
      .range_quarter_mm (req_tdata[33:16]),
      .quality          (req_tdata[41:34]),
      .out_ready        (rot_ready),
      .out_stage        (front_stage)
   );

   lp2c_rotator u_rotator (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (front_stage),
      .in_ready  (rot_ready),
      .out_ready (back_ready),
      .out_stage (rot_stage)
   );

   lp2c_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (rot_stage),
      .in_ready  (back_ready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .x_out     (x_out),
      .y_out     (y_out),
      .side_out  (side_out)
   );

   assign rsp_tdata = {2'b00, side_out.strength, side_out.angle, side_out.range, y_out, x_out};
   assign rsp_tuser = (side_out.range != '0);

endmodule
